// File: hdl/cbmv4_pkg.sv
// shared types and constants for the vrc4 bank mapper
package cbmv4_pkg;

   localparam int CHR_BANK_SLOTS = 8;
   localparam int ROM_ADDR_W = 22;

   localparam logic [1:0] MODE_CPU_RD = 2'd0;
   localparam logic [1:0] MODE_CPU_WR = 2'd1;
   localparam logic [1:0] MODE_PPU = 2'd2;

   localparam logic [3:0] PAGE_PRG0 = 4'h8;
   localparam logic [3:0] PAGE_CTRL = 4'h9;
   localparam logic [3:0] PAGE_PRG1 = 4'hA;
   localparam logic [3:0] PAGE_CHR_FIRST = 4'hB;
   localparam logic [3:0] PAGE_CHR_LAST = 4'hE;
   localparam logic [3:0] CTRL_SWAP_SEL = 4'h2;

   localparam logic [1:0] CPU_WIN_A000 = 2'd1;
   localparam logic [1:0] CPU_WIN_8000 = 2'd0;
   localparam logic [1:0] CPU_WIN_E000 = 2'd3;

   localparam logic [7:0] PRG_COUNT_RESET = 8'd16;

   typedef enum logic {
      PH_CLEAR,
      PH_RUN
   } phase_type;

   typedef struct packed {
      logic                  claimed;
      logic                  to_ram;
      logic                  ram_rd;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic [1:0]            mirroring;
   } stage_type;

endpackage

// File: hdl/cartridge_bank_mapper_vrc4.sv
// top level of the vrc4 bank mapper: register decode, address translation and work ram
//
// One bus access is taken per clock cycle, back to back, while the rsp side does not stall.
// Its answer first goes through the synchronous work ram access (one port, read or write)
// and the stage register, then the output register is loaded. After reset the work ram
// is cleared one byte per cycle, and req_tready stays low until the clear is done; csr
// writes are taken during that time. The bank count register
// (csr_wdata) should only be changed while no item is in flight.
module cartridge_bank_mapper_vrc4
   import cbmv4_pkg::*;
#(
   parameter int WORK_RAM_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // bus_addr[15:0], data_in[23:16]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rom_addr[21:0], read_byte[29:22], mirroring[31:30]
   output logic [1:0]  rsp_tuser,   // claimed[0], to_internal_ram[1]
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = $clog2(WORK_RAM_BYTES);
   localparam logic [13:0] WRB_W = 14'(WORK_RAM_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(WORK_RAM_BYTES - 1);

   function automatic logic [AW-1:0] wram_index(input logic [12:0] a);
      logic [13:0] r;
      r = {1'b0, a};
      for (int i = 0; i < 3; i++) begin
         if (r >= WRB_W) begin
            r = r - WRB_W;
         end
      end
      return r[AW-1:0];
   endfunction

   phase_type phase_ff, phase_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic [7:0] bank_count_ff;
   logic [3:0] prg_bank_ff [2];
   logic [7:0] chr_bank_ff [CHR_BANK_SLOTS];
   logic       swap_ff;
   logic [1:0] mirror_ff, mirror_in;

   logic [7:0] work_ram_ff [WORK_RAM_BYTES];
   logic [7:0] ram_rdata_ff;
   logic       ram_we, ram_re, clr_busy;
   logic [AW-1:0] ram_addr;
   logic [7:0] ram_wdata;

   logic       s1_valid_ff, s1_valid_in;
   stage_type  s1_ff, s1_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic        accept, s1_adv;
   logic [1:0]  mode;
   logic [15:0] addr;
   logic [7:0]  wdata;
   logic [3:0]  page;
   logic        is_cpu, in_ram, in_prg, reg_wr, chr_wr;
   logic [1:0]  chr_off;
   logic [2:0]  chr_idx;
   logic        chr_hi;
   logic [8:0]  last_bank, second_bank, prg_sel;
   logic [2:0]  ppu_slot;

   assign mode = req_tuser;
   assign addr = req_tdata[15:0];
   assign wdata = req_tdata[23:16];
   assign page = addr[15:12];

   // reset phase control
   always_comb begin
      phase_in = phase_ff;
      clr_cnt_in = clr_cnt_ff;
      case (phase_ff)
         PH_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            clr_cnt_in = clr_cnt_ff;
         end
         default: begin
            phase_in = PH_CLEAR;
         end
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_CLEAR: clr_busy = 1'b1;
         PH_RUN:   clr_busy = 1'b0;
         default:  clr_busy = 1'b1;
      endcase
   end

   assign s1_adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_adv);
   assign accept = req_tvalid && req_tready;

   // access decode and translation
   always_comb begin
      is_cpu = (mode == MODE_CPU_RD) || (mode == MODE_CPU_WR);
      in_ram = is_cpu && (addr[15:13] == 3'b011);
      in_prg = is_cpu && addr[15];
      reg_wr = accept && in_prg && (mode == MODE_CPU_WR);
      chr_wr = reg_wr && (page >= PAGE_CHR_FIRST) && (page <= PAGE_CHR_LAST);
      chr_off = 2'(page - PAGE_CHR_FIRST);
      chr_idx = {chr_off, addr[1] | addr[3]};
      chr_hi = addr[0] | addr[2];
      last_bank = {bank_count_ff, 1'b0} - 9'd1;
      second_bank = {bank_count_ff, 1'b0} - 9'd2;
      ppu_slot = addr[12:10];

      if (addr[14:13] == CPU_WIN_A000) begin
         prg_sel = {5'd0, prg_bank_ff[1]};
      end else if (addr[14:13] == CPU_WIN_E000) begin
         prg_sel = last_bank;
      end else if ((addr[14:13] == CPU_WIN_8000) == !swap_ff) begin
         prg_sel = {5'd0, prg_bank_ff[0]};
      end else begin
         prg_sel = second_bank;
      end

      mirror_in = mirror_ff;
      if (reg_wr && (page == PAGE_CTRL) && (addr[3:0] != CTRL_SWAP_SEL)) begin
         mirror_in = wdata[1:0];
      end

      s1_in.claimed = 1'b0;
      s1_in.to_ram = 1'b0;
      s1_in.ram_rd = 1'b0;
      s1_in.rom_addr = '0;
      s1_in.mirroring = mirror_in;
      if (in_ram) begin
         s1_in.claimed = 1'b1;
         s1_in.to_ram = 1'b1;
         s1_in.ram_rd = (mode == MODE_CPU_RD);
      end else if (in_prg && (mode == MODE_CPU_RD)) begin
         s1_in.claimed = 1'b1;
         s1_in.rom_addr = {prg_sel, addr[12:0]};
      end else if ((mode == MODE_PPU) && !addr[15] && !addr[14] && !addr[13]) begin
         s1_in.claimed = 1'b1;
         s1_in.rom_addr = {4'd0, chr_bank_ff[ppu_slot], addr[9:0]};
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   // work ram port
   always_comb begin
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_addr = wram_index(addr[12:0]);
      ram_wdata = wdata;
      if (clr_busy) begin
         ram_we = 1'b1;
         ram_addr = clr_cnt_ff;
         ram_wdata = 8'd0;
      end else if (accept && in_ram) begin
         ram_we = (mode == MODE_CPU_WR);
         ram_re = (mode == MODE_CPU_RD);
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         work_ram_ff[ram_addr] <= ram_wdata;
      end
      if (ram_re) begin
         ram_rdata_ff <= work_ram_ff[ram_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CLEAR;
         clr_cnt_ff <= '0;
         bank_count_ff <= PRG_COUNT_RESET;
         prg_bank_ff[0] <= 4'd0;
         prg_bank_ff[1] <= 4'd1;
         for (int i = 0; i < CHR_BANK_SLOTS; i++) begin
            chr_bank_ff[i] <= 8'd0;
         end
         swap_ff <= 1'b0;
         mirror_ff <= 2'd0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         clr_cnt_ff <= clr_cnt_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mirror_ff <= mirror_in;
         if (csr_wen) begin
            bank_count_ff <= csr_wdata;
         end
         if (reg_wr && (page == PAGE_PRG0)) begin
            prg_bank_ff[0] <= wdata[3:0];
         end
         if (reg_wr && (page == PAGE_PRG1)) begin
            prg_bank_ff[1] <= wdata[3:0];
         end
         if (reg_wr && (page == PAGE_CTRL) && (addr[3:0] == CTRL_SWAP_SEL)) begin
            swap_ff <= wdata[1];
         end
         if (chr_wr) begin
            if (chr_hi) begin
               chr_bank_ff[chr_idx] <= {wdata[3:0], chr_bank_ff[chr_idx][3:0]};
            end else begin
               chr_bank_ff[chr_idx] <= {chr_bank_ff[chr_idx][7:4], wdata[3:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= {s1_ff.mirroring, (s1_ff.ram_rd ? ram_rdata_ff : 8'd0),
                         s1_ff.rom_addr};
         rsp_user_ff <= {s1_ff.to_ram, s1_ff.claimed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready)
      else $error("item accepted during work ram clear");

   a_read_lands_in_stage : assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (s1_valid_ff && s1_ff.ram_rd))
      else $error("work ram read without matching stage entry");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_ff) && $stable(ram_rdata_ff)))
      else $error("stalled stage lost its item or ram data");

   a_ram_item_no_rom : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1]) |-> (rsp_user_ff[0] && (rsp_data_ff[21:0] == 22'd0)))
      else $error("work ram item carries a rom address");

endmodule

// File: test/cartridge_bank_mapper_vrc4_tb.sv
// testbench for cartridge_bank_mapper_vrc4: directed and random bus accesses
module cartridge_bank_mapper_vrc4_tb;
   import cbmv4_pkg::*;

   localparam int RAM_BYTES = 8192;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic                  claimed;
      logic                  to_ram;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic [7:0]            read_byte;
      logic [1:0]            mirroring;
   } bus_answer_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // bus_addr[15:0], data_in[23:16]
   logic [1:0]  req_tuser = '0;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // rom_addr[21:0], read_byte[29:22], mirroring[31:30]
   logic [1:0]  rsp_tuser;        // claimed[0], to_internal_ram[1]
   logic        csr_wen = 1'b0;
   logic [7:0]  csr_wdata = '0;

   // mapper image
   logic [7:0] prg_count = PRG_COUNT_RESET;
   logic [3:0] prg_img [2];
   logic [7:0] chr_img [CHR_BANK_SLOTS];
   logic [7:0] ram_image [RAM_BYTES];
   logic       swap_img = 1'b0;
   logic [1:0] mirror_img = 2'd0;

   bus_answer_type  answer_q [$];
   bus_answer_type  want;
   bus_answer_type  got;
   int              fail_count = 0;
   int              cycle_count = 0;
   stall_style_type rx_style = STALL_NONE;
   int              rx_left = 0;

   cartridge_bank_mapper_vrc4 #(
      .WORK_RAM_BYTES(RAM_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bus_answer_type translate_access(input logic [1:0] mode,
                                                       input logic [15:0] addr,
                                                       input logic [7:0] data);
      bus_answer_type ans;
      logic [8:0]  last_bank;
      logic [8:0]  second_last;
      logic [3:0]  page;
      logic [3:0]  chr_pair;
      logic [2:0]  slot;
      ans = '0;
      last_bank = {prg_count, 1'b0} - 9'd1;
      second_last = {prg_count, 1'b0} - 9'd2;
      page = addr[15:12];
      if (mode == MODE_CPU_RD || mode == MODE_CPU_WR) begin
         if (addr >= 16'h6000 && addr <= 16'h7FFF) begin
            ans.claimed = 1'b1;
            ans.to_ram = 1'b1;
            if (mode == MODE_CPU_WR) begin
               ram_image[addr[12:0]] = data;
            end else begin
               ans.read_byte = ram_image[addr[12:0]];
            end
         end else if (addr[15]) begin
            if (mode == MODE_CPU_WR) begin
               if (page == PAGE_PRG0) begin
                  prg_img[0] = data[3:0];
               end else if (page == PAGE_PRG1) begin
                  prg_img[1] = data[3:0];
               end else if (page == PAGE_CTRL) begin
                  if (addr[3:0] == CTRL_SWAP_SEL) begin
                     swap_img = data[1];
                  end else begin
                     mirror_img = data[1:0];
                  end
               end else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
                  chr_pair = page - PAGE_CHR_FIRST;
                  slot = {chr_pair[1:0], addr[1] | addr[3]};
                  if (addr[0] | addr[2]) begin
                     chr_img[slot][7:4] = data[3:0];
                  end else begin
                     chr_img[slot][3:0] = data[3:0];
                  end
               end
            end else begin
               ans.claimed = 1'b1;
               if (addr[14:13] == CPU_WIN_A000) begin
                  ans.rom_addr = {5'b0, prg_img[1], addr[12:0]};
               end else if (addr[14:13] == CPU_WIN_E000) begin
                  ans.rom_addr = {last_bank, addr[12:0]};
               end else if ((addr[14:13] == CPU_WIN_8000) == !swap_img) begin
                  ans.rom_addr = {5'b0, prg_img[0], addr[12:0]};
               end else begin
                  ans.rom_addr = {second_last, addr[12:0]};
               end
            end
         end
      end else if (mode == MODE_PPU && addr < 16'h2000) begin
         ans.claimed = 1'b1;
         ans.rom_addr = {4'b0, chr_img[addr[12:10]], addr[9:0]};
      end
      ans.mirroring = mirror_img;
      return ans;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style <= stall_style_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_style)
         STALL_NONE: rsp_tready <= 1'b1;
         STALL_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 9) < 3);
         default: rsp_tready <= (rx_left % 8 < 3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.claimed = rsp_tuser[0];
         got.to_ram = rsp_tuser[1];
         got.rom_addr = rsp_tdata[21:0];
         got.read_byte = rsp_tdata[29:22];
         got.mirroring = rsp_tdata[31:30];
         if (answer_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected item: claimed %0d ram %0d rom %06h byte %02h mirror %0d",
                        got.claimed, got.to_ram, got.rom_addr, got.read_byte, got.mirroring);
            end
         end else begin
            want = answer_q.pop_front();
            if (got.claimed !== want.claimed || got.to_ram !== want.to_ram ||
                got.rom_addr !== want.rom_addr || got.read_byte !== want.read_byte ||
                got.mirroring !== want.mirroring) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch: want claimed %0d ram %0d rom %06h byte %02h mirror %0d",
                           want.claimed, want.to_ram, want.rom_addr, want.read_byte,
                           want.mirroring);
                  $display("           got claimed %0d ram %0d rom %06h byte %02h mirror %0d",
                           got.claimed, got.to_ram, got.rom_addr, got.read_byte,
                           got.mirroring);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL cartridge_bank_mapper_vrc4");
         $finish;
      end
   end

   task automatic send_access(input logic [1:0] mode, input logic [15:0] addr,
                              input logic [7:0] data);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answer_q.push_back(translate_access(mode, addr, data));
   endtask

   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bank_count(input logic [7:0] count);
      csr_wen <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_wen <= 1'b0;
      prg_count = count;
   endtask

   task automatic test_work_ram;
      send_access(MODE_CPU_WR, 16'h6000, 8'hFF);
      send_access(MODE_CPU_RD, 16'h6000, 8'h00);
      send_access(MODE_CPU_RD, 16'h7FFF, 8'hFF);
   endtask

   task automatic test_prg_banking;
      send_access(MODE_CPU_WR, 16'h8000, 8'hFF);
      send_access(MODE_CPU_WR, 16'hA00F, 8'hA5);
      send_access(MODE_CPU_RD, 16'h8000, 8'h00);
      send_access(MODE_CPU_RD, 16'hBFFF, 8'h00);
      send_access(MODE_CPU_RD, 16'hC000, 8'h00);
      send_access(MODE_CPU_RD, 16'hFFFF, 8'h00);
      // swap mode on, then reread the swapped windows
      send_access(MODE_CPU_WR, 16'h9002, 8'h02);
      send_access(MODE_CPU_RD, 16'h9FFF, 8'h00);
      send_access(MODE_CPU_RD, 16'hD123, 8'h00);
      send_access(MODE_CPU_WR, 16'h9001, 8'h03);
   endtask

   task automatic test_chr_banking;
      send_access(MODE_CPU_WR, 16'hB000, 8'h0F);
      send_access(MODE_CPU_WR, 16'hE00F, 8'hFF);
      send_access(MODE_CPU_WR, 16'hE004, 8'h0A);
      send_access(MODE_PPU, 16'h0000, 8'h00);
      send_access(MODE_PPU, 16'h1FFF, 8'hFF);
      send_access(MODE_PPU, 16'h1800, 8'h00);
      send_access(MODE_PPU, 16'h2000, 8'h00);
   endtask

   task automatic test_unclaimed;
      send_access(MODE_CPU_RD, 16'h5FFF, 8'h00);
      send_access(MODE_CPU_WR, 16'hF003, 8'hFF);
      send_access(MODE_NONE, 16'h8000, 8'h55);
      send_access(MODE_CPU_WR, 16'h1234, 8'hAA);
      send_access(MODE_CPU_RD, 16'h0000, 8'h00);
   endtask

   task automatic send_random_access;
      int          kind;
      logic [1:0]  mode;
      logic [15:0] addr;
      logic [7:0]  data;
      kind = $urandom_range(0, 99);
      addr = 16'($urandom);
      data = 8'($urandom);
      if (kind < 30) begin
         mode = MODE_CPU_WR;
         addr[15] = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            addr[15:12] = PAGE_CTRL;
            if ($urandom_range(0, 1) == 0) addr[3:0] = CTRL_SWAP_SEL;
         end
      end else if (kind < 50) begin
         mode = MODE_CPU_RD;
         addr[15] = 1'b1;
      end else if (kind < 80) begin
         mode = (kind < 65) ? MODE_CPU_WR : MODE_CPU_RD;
         addr[15:13] = 3'b011;
         // crowd ram accesses into the ends so reads hit earlier writes
         case ($urandom_range(0, 2))
            0: addr[12:5] = 8'h00;
            1: addr[12:5] = 8'hFF;
            default: ;
         endcase
      end else if (kind < 95) begin
         mode = MODE_PPU;
         if ($urandom_range(0, 7) != 0) addr[15:13] = 3'b000;
      end else begin
         mode = 2'($urandom_range(0, 3));
      end
      send_access(mode, addr, data);
   endtask

   task automatic test_random_traffic(input int count);
      int burst_left;
      int gap;
      burst_left = 0;
      repeat (count) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         send_random_access();
      end
      wait_idle();
   endtask

   initial begin
      logic [7:0] counts [5];
      counts[0] = 8'd1;
      counts[1] = 8'd255;
      counts[2] = 8'd0;
      counts[3] = 8'($urandom_range(2, 254));
      counts[4] = PRG_COUNT_RESET;
      prg_img[0] = 4'd0;
      prg_img[1] = 4'd1;
      foreach (chr_img[i]) chr_img[i] = '0;
      foreach (ram_image[i]) ram_image[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_work_ram();
      test_prg_banking();
      test_chr_banking();
      test_unclaimed();
      wait_idle();

      foreach (counts[i]) begin
         write_bank_count(counts[i]);
         test_random_traffic(375);
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && answer_q.size() == 0) begin
         $display("PASS cartridge_bank_mapper_vrc4");
      end else begin
         $display("FAIL cartridge_bank_mapper_vrc4");
      end
      $finish;
   end

endmodule
